### sv/pas_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and the CORDIC arctangent table for the motion sequencer.
// No dependencies; every other file imports this package.
package pas_pkg;

	// Item kinds carried in tuser
	localparam logic [1:0] FUNC_POSE = 2'd0;
	localparam logic [1:0] FUNC_GOAL = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// Motion phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TURN  = 2'd1;
	localparam logic [1:0] PH_DRIVE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_TURN_STEP  = 1'b0;
	localparam logic CFG_DRIVE_STEP = 1'b1;

	// Angle constants, Q3.13 and CORDIC accumulator scale (30 fraction bits)
	localparam logic signed [16:0] ANG_PI       = 17'sd25736;
	localparam logic signed [16:0] ANG_TWO_PI   = 17'sd51472;
	localparam logic signed [35:0] HALF_PI_Z    = 36'sd1686629713;

	// CORDIC datapath widths
	localparam int CW = 40;   // x / y width
	localparam int ZW = 36;   // angle accumulator width
	localparam int IN_W = 36; // vector input width

	// Square root: 33 digit steps over a 66-bit radicand
	localparam int SQRT_STEPS = 33;

	// Arctangent of 2^-i scaled by 2^30
	function automatic logic [29:0] atan_entry(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/pas_cordic.sv
`timescale 1ns / 1ps
// Iterative vectoring CORDIC: atan2(y, x) in Q3.13, one micro-rotation per cycle.
// Depends on pas_pkg.
module pas_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [pas_pkg::IN_W-1:0]    y_in,
	input  logic signed [pas_pkg::IN_W-1:0]    x_in,
	output logic                               done,
	output logic signed [15:0]                 angle
);
	import pas_pkg::*;

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_NORM = 4'b0010,
		C_ROT  = 4'b0100,
		C_DONE = 4'b1000
	} cordic_state_t;

	cordic_state_t       state_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0]       iter_q;
	logic                done_q;
	logic signed [15:0]  angle_q;

	logic [CW-1:0]        mag_x, mag_y;
	logic [4:0]           sh;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] atan_z;
	logic signed [ZW-1:0] z_rnd;
	logic signed [18:0]   r;

	// Magnitudes for normalization
	assign mag_x = x_q[CW-1] ? CW'(-x_q) : x_q;
	assign mag_y = y_q[CW-1] ? CW'(-y_q) : y_q;

	// Shared shift-add unit
	assign sh     = 5'(iter_q);
	assign dx     = y_q >>> sh;
	assign dy     = x_q >>> sh;
	assign atan_z = ZW'(atan_entry(sh));

	// Round half up to Q3.13
	assign z_rnd = z_q + ZW'(65536);
	assign r     = 19'(z_rnd >>> 17);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			// pulse done as the angle is loaded
			done_q <= (state_q == C_DONE);
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q    <= CW'(x_in);
						y_q    <= CW'(y_in);
						z_q    <= '0;
						iter_q <= '0;
						// zero vector reads as angle zero
						state_q <= (x_in == '0 && y_in == '0) ? C_DONE : C_NORM;
					end
				end
				C_NORM: begin
					if (mag_x < (CW'(1) << 27) && mag_y < (CW'(1) << 27)) begin
						x_q <= x_q <<< 8;
						y_q <= y_q <<< 8;
					end else if (mag_x < (CW'(1) << 35) && mag_y < (CW'(1) << 35)) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						// fold the left half plane by a quarter turn
						if (x_q[CW-1]) begin
							if (!y_q[CW-1]) begin
								x_q <= y_q;
								y_q <= -x_q;
								z_q <= HALF_PI_Z;
							end else begin
								x_q <= -y_q;
								y_q <= x_q;
								z_q <= -HALF_PI_Z;
							end
						end
						state_q <= C_ROT;
					end
				end
				C_ROT: begin
					if (!y_q[CW-1]) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_z;
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_z;
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == IW'(CORDIC_STEPS - 1))
						state_q <= C_DONE;
				end
				C_DONE: begin
					if (r > 19'(ANG_PI))
						angle_q <= 16'(ANG_PI);
					else if (r < -19'(ANG_PI))
						angle_q <= -16'(ANG_PI);
					else
						angle_q <= 16'(r);
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

### sv/pas_isqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root, floor(sqrt(v)) of a 66-bit value, 2 bits per cycle.
// Depends on pas_pkg.
module pas_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] radicand,
	output logic        done,
	output logic [32:0] root
);
	import pas_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [65:0] val_q;
	logic [33:0] rem_q;
	logic [32:0] root_q;

	logic [35:0] rem2, trial;

	// Bring down two bits and try the next root digit
	assign rem2  = {rem_q, val_q[65:64]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse done with the last digit
			done_q <= busy_q && !start && (cnt_q == 6'(SQRT_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				val_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				val_q <= val_q << 2;
				if (rem2 >= trial) begin
					rem_q  <= 34'(rem2 - trial);
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem2[33:0];
					root_q <= {root_q[31:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(SQRT_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### sv/point_and_shoot_motion_sequencer.sv
`timescale 1ns / 1ps
// Top level of the point-and-shoot motion sequencer: sequencer, shared multiplier, state.
// Depends on pas_pkg, pas_cordic and pas_isqrt.
//
//  Channel | Direction | Signals                          | Content
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | pose, goal or tick item
//  m_      | out       | m_tvalid m_tready m_tdata         | motor commands and status
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data | step registers
//
// A tick or an unused code goes straight from transfer to the final step. A pose runs its
// four products through the shared multiplier, then CORDIC normalization and CORDIC_STEPS
// rotations; a goal runs two products, then the CORDIC and the 33-step square root, which
// runs beside the CORDIC. s_tready is high only while the sequencer is idle; a result
// waiting on m_tready holds the sequencer in its final step. Reset clears the control and
// motion state and loads the step registers with their defaults; cfg_ready is always high.
module point_and_shoot_motion_sequencer #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // pos_x, pos_y, quat_w, quat_x, quat_y, quat_z
	input  logic [1:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [55:0]  m_tdata,  // cmd_turn, cmd_forward, phase, heading_error,
	                               // goal_distance, zero fill
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import pas_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MUL    = 4'b0010,
		ST_ANGLE  = 4'b0100,
		ST_FINISH = 4'b1000
	} seq_state_t;

	seq_state_t state_q;

	// Configuration
	logic [14:0] turn_step_q;
	logic [31:0] drive_step_q;

	// Item registers
	logic [1:0]          func_q;
	logic signed [32:0]  dx_q, dy_q;
	logic signed [15:0]  qw_q, qx_q, qy_q, qz_q;
	logic [2:0]          mul_cnt_q;
	logic signed [65:0]  prod_s1;
	logic signed [65:0]  sacc_q, cacc_q;
	logic                start_q, cdone_q, sdone_q;

	// Sequencer state
	logic signed [31:0]  cur_x_q, cur_y_q;
	logic signed [15:0]  cur_yaw_q;
	logic [1:0]          mode_q;
	logic                turn_sign_q;
	logic [15:0]         turned_q, turn_target_q;
	logic [33:0]         driven_q;
	logic [32:0]         drive_target_q;
	logic signed [15:0]  last_error_q;

	// Output register
	logic                m_tvalid_q;
	logic [55:0]         m_tdata_q;

	logic signed [31:0]  in_x, in_y;
	logic                s_xfer, out_free, is_pose;
	logic [2:0]          mul_n, acc_idx;
	logic signed [32:0]  op_a, op_b, ux, uy;
	logic signed [65:0]  prod;
	logic signed [IN_W-1:0] cy_in, cx_in;
	logic [65:0]         radicand;
	logic                cordic_done, sqrt_done;
	logic signed [15:0]  angle;
	logic [32:0]         root;

	logic signed [16:0]  err_raw, err_wrap;
	logic [15:0]         turned_nx;
	logic [33:0]         driven_nx;
	logic [1:0]          mode_nx;
	logic                sign_nx;
	logic [15:0]         err_nx;
	logic [32:0]         dist_nx;
	logic [1:0]          cmd_turn_nx;

	assign in_x     = s_tdata[31:0];
	assign in_y     = s_tdata[63:32];
	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign is_pose  = (func_q == FUNC_POSE);
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_step_q  <= 15'd82;
			drive_step_q <= 32'd655;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TURN_STEP:  turn_step_q  <= cfg_data[14:0];
				CFG_DRIVE_STEP: drive_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier operands
	assign ux = dx_q[32] ? -dx_q : dx_q;
	assign uy = dy_q[32] ? -dy_q : dy_q;
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (is_pose) begin
			case (mul_cnt_q[1:0])
				2'd0: begin op_a = 33'(qw_q); op_b = 33'(qz_q); end
				2'd1: begin op_a = 33'(qx_q); op_b = 33'(qy_q); end
				2'd2: begin op_a = 33'(qy_q); op_b = 33'(qy_q); end
				default: begin op_a = 33'(qz_q); op_b = 33'(qz_q); end
			endcase
		end else begin
			op_a = mul_cnt_q[0] ? uy : ux;
			op_b = op_a;
		end
	end
	assign prod    = op_a * op_b;
	assign mul_n   = is_pose ? 3'd4 : 3'd2;
	assign acc_idx = mul_cnt_q - 3'd1;

	// CORDIC vector and square-root radicand
	always_comb begin
		if (is_pose) begin
			cy_in = {sacc_q[34:0], 1'b0};
			cx_in = IN_W'(36'sd268435456 - {cacc_q[34:0], 1'b0});
		end else begin
			cy_in = IN_W'(dy_q);
			cx_in = IN_W'(dx_q);
		end
	end
	assign radicand = 66'(sacc_q) + 66'(cacc_q);

	pas_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.y_in   (cy_in),
		.x_in   (cx_in),
		.done   (cordic_done),
		.angle  (angle)
	);

	pas_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q && !is_pose),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (root)
	);

	// Heading error wrapped to plus or minus pi
	assign err_raw = 17'(angle) - 17'(cur_yaw_q);
	always_comb begin
		if (err_raw > ANG_PI)
			err_wrap = err_raw - ANG_TWO_PI;
		else if (err_raw < -ANG_PI)
			err_wrap = err_raw + ANG_TWO_PI;
		else
			err_wrap = err_raw;
	end

	// Next motion state for the item in its final step
	assign turned_nx = turned_q + 16'(turn_step_q);
	assign driven_nx = driven_q + 34'(drive_step_q);
	always_comb begin
		mode_nx = mode_q;
		sign_nx = turn_sign_q;
		err_nx  = last_error_q;
		dist_nx = drive_target_q;
		case (func_q)
			FUNC_GOAL: begin
				err_nx  = 16'(err_wrap);
				dist_nx = root;
				sign_nx = err_wrap[16];
				mode_nx = (err_wrap != '0) ? PH_TURN : PH_DRIVE;
			end
			FUNC_TICK: begin
				if (mode_q == PH_TURN) begin
					if (turned_nx >= turn_target_q)
						mode_nx = PH_DRIVE;
				end else if (mode_q == PH_DRIVE) begin
					if (driven_nx >= 34'(drive_target_q))
						mode_nx = PH_IDLE;
				end
			end
			default: ;
		endcase
	end
	assign cmd_turn_nx = (mode_nx == PH_TURN) ? (sign_nx ? 2'b11 : 2'b01) : 2'b00;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			start_q        <= 1'b0;
			cdone_q        <= 1'b0;
			sdone_q        <= 1'b0;
			mul_cnt_q      <= '0;
			func_q         <= FUNC_TICK;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			cur_yaw_q      <= '0;
			mode_q         <= PH_IDLE;
			turn_sign_q    <= 1'b0;
			turned_q       <= '0;
			turn_target_q  <= '0;
			driven_q       <= '0;
			drive_target_q <= '0;
			last_error_q   <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			// kick the angle unit, and for a goal the root unit, after the last product
			start_q <= (state_q == ST_MUL) && (mul_cnt_q == mul_n);
			if (m_tvalid_q && m_tready && state_q != ST_FINISH)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						func_q    <= s_tuser;
						qw_q      <= s_tdata[79:64];
						qx_q      <= s_tdata[95:80];
						qy_q      <= s_tdata[111:96];
						qz_q      <= s_tdata[127:112];
						dx_q      <= 33'(in_x) - 33'(cur_x_q);
						dy_q      <= 33'(in_y) - 33'(cur_y_q);
						sacc_q    <= '0;
						cacc_q    <= '0;
						mul_cnt_q <= '0;
						if (s_tuser == FUNC_POSE) begin
							cur_x_q <= in_x;
							cur_y_q <= in_y;
						end
						if (s_tuser == FUNC_POSE || s_tuser == FUNC_GOAL)
							state_q <= ST_MUL;
						else
							state_q <= ST_FINISH;
					end
				end
				ST_MUL: begin
					// one product per cycle, registered in prod_s1 and then accumulated
					if (mul_cnt_q < mul_n)
						prod_s1 <= prod;
					if (mul_cnt_q != '0) begin
						if (acc_idx < (mul_n >> 1))
							sacc_q <= sacc_q + prod_s1;
						else
							cacc_q <= cacc_q + prod_s1;
					end
					mul_cnt_q <= mul_cnt_q + 3'd1;
					if (mul_cnt_q == mul_n) begin
						cdone_q <= 1'b0;
						sdone_q <= is_pose;
						state_q <= ST_ANGLE;
					end
				end
				ST_ANGLE: begin
					if (cordic_done)
						cdone_q <= 1'b1;
					if (sqrt_done)
						sdone_q <= 1'b1;
					if (cdone_q && sdone_q)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						case (func_q)
							FUNC_POSE: cur_yaw_q <= angle;
							FUNC_GOAL: begin
								last_error_q   <= err_nx;
								drive_target_q <= dist_nx;
								turn_sign_q    <= sign_nx;
								turn_target_q  <= err_wrap[16] ? 16'(-err_wrap)
								                               : 16'(err_wrap);
								turned_q       <= '0;
								driven_q       <= '0;
							end
							FUNC_TICK: begin
								if (mode_q == PH_TURN) begin
									turned_q <= turned_nx;
									if (mode_nx == PH_DRIVE)
										driven_q <= '0;
								end else if (mode_q == PH_DRIVE) begin
									driven_q <= driven_nx;
								end
							end
							default: ;
						endcase
						mode_q     <= mode_nx;
						m_tdata_q  <= {2'b00, dist_nx, err_nx, mode_nx,
						               (mode_nx == PH_DRIVE), cmd_turn_nx};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
